/* hw/rtl/mec_pkg.sv */
// ----------------------------------------------------------------------------
// mec_pkg
// Types, command codes and constant tables for the multiband envelope
// compressor.
// ----------------------------------------------------------------------------
package mec_pkg;

   localparam int BAND_IDX_BITS  = 3;
   localparam int STEP_BITS      = 4;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [18:0] DB_K       = 19'd394566;
   localparam logic [13:0] EXP_K      = 14'd10885;
   localparam logic signed [15:0] DB_AT_ZERO = -16'sd25600;

   typedef logic [7:0][31:0]  reg_default_type;
   typedef logic [16:0][31:0] pow_tab_type;

   localparam reg_default_type REG_DEFAULTS = '{
      32'd3221231884, 32'd2879060736, 32'd2577015056, 32'd3886283264,
      32'd2863343892, 32'd4188993536, 32'd2147494164, 32'd4273600000
   };

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] rem;
      logic [63:0] bit_v;
      r     = '0;
      rem   = v;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + bit_v) begin
            rem = rem - (r + bit_v);
            r   = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   function automatic pow_tab_type make_pow_tab();
      pow_tab_type tab;
      logic [63:0] c;
      tab[0] = 32'h4000_0000;
      c      = isqrt64(64'h0800_0000_0000_0000);
      tab[1] = c[31:0];
      for (int i = 2; i <= 16; i++) begin
         c      = isqrt64(c << 30);
         tab[i] = c[31:0];
      end
      return tab;
   endfunction

   localparam pow_tab_type POW_FACTOR = make_pow_tab();

   typedef enum logic [3:0] {
      OP_IDLE, OP_LOAD, OP_COPY, OP_ENV, OP_NORM, OP_LOG, OP_DB,
      OP_RED, OP_EXPT, OP_POW, OP_GAIN, OP_ACC, OP_OUT
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_COPY, ST_ENV, ST_NORM, ST_LOG, ST_DB, ST_RED,
      ST_EXPT, ST_POW, ST_GAIN, ST_ACC, ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type                op;
      logic [BAND_IDX_BITS-1:0] band;
      logic [STEP_BITS-1:0]     step;
   } dp_cmd_type;

   typedef struct packed {
      logic norm_done;
      logic env_zero;
   } dp_status_type;

endpackage

/* hw/rtl/mec_ctrl.sv */
// ----------------------------------------------------------------------------
// mec_ctrl
// Sequencer: walks each band through envelope, log, gain and accumulate
// steps, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mec_ctrl
   import mec_pkg::*;
#(
   parameter int BAND_COUNT = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type           state_ff, state_in;
   logic [BAND_IDX_BITS-1:0] band_ff, band_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;
   logic                     last_band;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_band = band_ff == BAND_IDX_BITS'(BAND_COUNT - 1);

   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COPY;
               band_in  = '0;
            end
         end
         ST_COPY: state_in = ST_ENV;
         ST_ENV:  state_in = ST_NORM;
         ST_NORM: begin
            if (status.env_zero) begin
               state_in = ST_DB;
            end else if (status.norm_done) begin
               state_in = ST_LOG;
               step_in  = '0;
            end
         end
         ST_LOG: begin
            step_in = step_ff + 1'b1;
            if (&step_ff) state_in = ST_DB;
         end
         ST_DB:   state_in = ST_RED;
         ST_RED:  state_in = ST_EXPT;
         ST_EXPT: begin
            state_in = ST_POW;
            step_in  = '0;
         end
         ST_POW: begin
            step_in = step_ff + 1'b1;
            if (&step_ff) state_in = ST_GAIN;
         end
         ST_GAIN: state_in = ST_ACC;
         ST_ACC: begin
            if (last_band) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_COPY;
               band_in  = band_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.band = band_ff;
      cmd.step = step_ff;
      case (state_ff)
         ST_IDLE: cmd.op = req_valid ? OP_LOAD : OP_IDLE;
         ST_COPY: cmd.op = OP_COPY;
         ST_ENV:  cmd.op = OP_ENV;
         ST_NORM: cmd.op = OP_NORM;
         ST_LOG:  cmd.op = OP_LOG;
         ST_DB:   cmd.op = OP_DB;
         ST_RED:  cmd.op = OP_RED;
         ST_EXPT: cmd.op = OP_EXPT;
         ST_POW:  cmd.op = OP_POW;
         ST_GAIN: cmd.op = OP_GAIN;
         ST_ACC:  cmd.op = OP_ACC;
         ST_DONE: cmd.op = out_free ? OP_OUT : OP_IDLE;
         default: cmd.op = OP_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.op == OP_OUT) rsp_valid_in = 1'b1;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         band_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         band_ff      <= band_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/mec_datapath.sv */
// ----------------------------------------------------------------------------
// mec_datapath
// Band registers, envelopes and the arithmetic steps driven by the
// sequencer commands.
// ----------------------------------------------------------------------------
module mec_datapath
   import mec_pkg::*;
#(
   parameter int BAND_COUNT  = 4,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dp_cmd_type                      cmd,
   output dp_status_type                   status,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample_in,
   input  logic                            csr_write,
   input  logic [CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_data,
   output logic signed [SAMPLE_BITS-1:0]   rsp_sample_out,
   output logic                            rsp_was_clipped
);

   localparam int SB    = SAMPLE_BITS;
   localparam int CW    = SB + 17;
   localparam int AW    = SB + 4;
   localparam int NREG  = 2 * BAND_COUNT;
   localparam int RIW   = $clog2(NREG);
   localparam int BIW   = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
   localparam logic signed [AW-1:0] LIMIT = AW'(1) <<< (SB - 2);

   logic [31:0] cfg_ff [NREG];
   logic [31:0] env_ff [BAND_COUNT];

   logic signed [SB-1:0]  sample_ff;
   logic signed [CW-1:0]  copy_ff, copy_in;
   logic signed [AW-1:0]  acc_ff, acc_in;
   logic [31:0]           m_ff, m_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic                  zero_ff, zero_in;
   logic [15:0]           frac_ff, frac_in;
   logic signed [15:0]    lvl_ff, lvl_in;
   logic [15:0]           red_ff, red_in;
   logic [21:0]           t_ff, t_in;
   logic [30:0]           p_ff, p_in;
   logic signed [17:0]    g_ff, g_in;
   logic signed [SB-1:0]  out_ff, out_in;
   logic                  clip_ff, clip_in;

   logic [31:0]           r0, r1, cur_env, env_new, mag, d;
   logic [CW-1:0]         copy_abs;
   logic                  up;
   logic [7:0]            coef;
   logic [39:0]           dprod;
   logic [63:0]           sq;
   logic [33:0]           sh;
   logic [5:0]            neg_cnt;
   logic signed [21:0]    lval;
   logic signed [41:0]    dbprod;
   logic signed [17:0]    dbs;
   logic signed [15:0]    thr;
   logic signed [16:0]    diff;
   logic [31:0]           rprod;
   logic [29:0]           tprod;
   logic [61:0]           pprod;
   logic [5:0]            ip;
   logic [30:0]           pp;
   logic [16:0]           gain16;
   logic signed [CW+17:0] aprod;
   logic signed [CW-15:0] contrib;

   assign r0      = cfg_ff[RIW'({cmd.band, 1'b0})];
   assign r1      = cfg_ff[RIW'({cmd.band, 1'b1})];
   assign cur_env = env_ff[BIW'(cmd.band)];
   assign thr     = $signed(r0[15:0]);

   always_comb begin
      copy_in  = CW'(sample_ff * $signed({1'b0, r0[31:16]}));
      copy_abs = copy_ff[CW-1] ? CW'(-copy_ff) : CW'(copy_ff);
      mag      = 32'(copy_abs >> (SB - 16));
      up       = mag > cur_env;
      d        = up ? mag - cur_env : cur_env - mag;
      coef     = up ? r1[15:8] : r1[7:0];
      dprod    = 40'(d) * 40'(coef);
      env_new  = up ? cur_env + 32'(dprod[39:12]) : cur_env - 32'(dprod[39:12]);
      sq       = 64'(m_ff) * 64'(m_ff);
      sh       = sq[63:30];
      neg_cnt  = 6'd0 - {1'b0, cnt_ff};
      lval     = $signed({neg_cnt, frac_ff});
      dbprod   = lval * $signed({1'b0, DB_K});
      dbs      = dbprod[41:24];
      diff     = $signed({lvl_ff[15], lvl_ff}) - $signed({thr[15], thr});
      rprod    = 32'(diff[15:0]) * 32'(r1[31:16]);
      tprod    = 30'(red_ff) * 30'(EXP_K);
      pprod    = 62'(p_ff) * 62'(POW_FACTOR[5'(cmd.step) + 5'd1]);
      ip       = t_ff[21:16];
      pp       = (ip >= 6'd31) ? '0 : p_ff >> ip;
      gain16   = pp[30:14];
      aprod    = copy_ff * g_ff;
      contrib  = aprod[CW+17:32];
   end

   always_comb begin
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      zero_in = zero_ff;
      frac_in = frac_ff;
      lvl_in  = lvl_ff;
      red_in  = red_ff;
      t_in    = t_ff;
      p_in    = p_ff;
      g_in    = g_ff;
      acc_in  = acc_ff;
      out_in  = out_ff;
      clip_in = clip_ff;
      case (cmd.op)
         OP_LOAD: acc_in = AW'(req_sample_in);
         OP_ENV: begin
            m_in    = env_new;
            cnt_in  = '0;
            zero_in = env_new == '0;
            frac_in = '0;
         end
         OP_NORM: begin
            if (!m_ff[30] && !zero_ff) begin
               m_in   = m_ff << 1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         OP_LOG: begin
            frac_in = {frac_ff[14:0], sh[31]};
            m_in    = sh[31] ? sh[32:1] : sh[31:0];
         end
         OP_DB: begin
            if (zero_ff) lvl_in = DB_AT_ZERO;
            else if (dbs < -18'sd32768) lvl_in = -16'sd32768;
            else if (dbs > 18'sd32767) lvl_in = 16'sd32767;
            else lvl_in = dbs[15:0];
         end
         OP_RED:  red_in = (lvl_ff > thr) ? rprod[31:16] : '0;
         OP_EXPT: begin
            t_in = tprod[29:8];
            p_in = 31'h4000_0000;
         end
         OP_POW: begin
            if (t_ff[4'd15 - cmd.step]) p_in = pprod[60:30];
         end
         OP_GAIN: g_in = $signed({1'b0, gain16}) - 18'sd65536;
         OP_ACC:  acc_in = acc_ff + AW'(contrib);
         OP_OUT: begin
            clip_in = (acc_ff > LIMIT) || (acc_ff < -LIMIT);
            if (acc_ff > LIMIT) out_in = SB'(LIMIT);
            else if (acc_ff < -LIMIT) out_in = SB'(-LIMIT);
            else out_in = SB'(acc_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREG; i++) begin
            cfg_ff[i] <= (i < 8) ? REG_DEFAULTS[i % 8] : '0;
         end
         for (int i = 0; i < BAND_COUNT; i++) begin
            env_ff[i] <= '0;
         end
      end else begin
         if (csr_write && (32'(csr_index) < 32'(NREG))) begin
            cfg_ff[RIW'(csr_index)] <= csr_data;
         end
         if (cmd.op == OP_ENV) env_ff[BIW'(cmd.band)] <= env_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) sample_ff <= req_sample_in;
      if (cmd.op == OP_COPY) copy_ff <= copy_in;
      m_ff    <= m_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
      frac_ff <= frac_in;
      lvl_ff  <= lvl_in;
      red_ff  <= red_in;
      t_ff    <= t_in;
      p_ff    <= p_in;
      g_ff    <= g_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
      clip_ff <= clip_in;
   end

   assign status.norm_done = m_ff[30];
   assign status.env_zero  = zero_ff;
   assign rsp_sample_out   = out_ff;
   assign rsp_was_clipped  = clip_ff;

endmodule

/* hw/rtl/multiband_envelope_compressor.sv */
// Sequence: per band, copy, envelope update, normalize loop, 16 log squaring
// steps, dB conversion, reduction, exponent, 16 exponent factor steps, gain
// and accumulate (a zero envelope skips from normalize to dB); then the output
// register is loaded. New samples are taken only when idle; a stalled result
// holds the sequencer in its final state and the next sample waits.
// Reset: synchronous, clears envelopes and control, loads default registers.
// ----------------------------------------------------------------------------
// multiband_envelope_compressor
// Four-band peak-envelope compressor, one sample in, one sample out.
// ----------------------------------------------------------------------------
module multiband_envelope_compressor
   import mec_pkg::*;
#(
   parameter int BAND_COUNT  = 4,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_was_clipped,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   mec_ctrl #(.BAND_COUNT(BAND_COUNT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mec_datapath #(.BAND_COUNT(BAND_COUNT), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample_in   (req_sample_in),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_was_clipped (rsp_was_clipped)
   );

endmodule

/* hw/rtl/mec_checker.sv */
// ----------------------------------------------------------------------------
// mec_checker
// Port-level checks for the compressor, bound to the top level.
// ----------------------------------------------------------------------------
module mec_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                          rsp_was_clipped
);

   localparam logic signed [SAMPLE_BITS-1:0] LIMIT = SAMPLE_BITS'(1) <<< (SAMPLE_BITS - 2);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled transaction changed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new transaction taken while busy");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_out <= LIMIT) && (rsp_sample_out >= -LIMIT))
      else $error("output outside clamp range");

   a_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_clipped |-> rsp_sample_out == LIMIT || rsp_sample_out == -LIMIT)
      else $error("clip flag without clamped value");

endmodule

bind multiband_envelope_compressor mec_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mec_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_sample_out  (rsp_sample_out),
   .rsp_was_clipped (rsp_was_clipped)
);

/* sim/tb_multiband_envelope_compressor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiband_envelope_compressor
// Drives audio samples through the four-band compressor under random bursts,
// output stalls and several register settings, and checks every output
// sample and clip flag against a bit-exact predictor of the band chain.
// ----------------------------------------------------------------------------
module tb_multiband_envelope_compressor;
   import mec_pkg::*;

   localparam int BANDS       = 4;
   localparam int SBITS       = 24;
   localparam int NUM_REGS    = 2 * BANDS;
   localparam int SETTLE      = 400;
   localparam int WATCHDOG    = 20000;
   localparam int HOLDOFF     = 3000;
   localparam int PHASE_ITEMS = 270;

   localparam logic signed [SBITS-1:0] FULL_POS = 24'sh7FFFFF;
   localparam logic signed [SBITS-1:0] FULL_NEG = 24'sh800000;
   localparam logic signed [SBITS-1:0] UNITY    = 24'sh400000;

   typedef struct {
      logic signed [SBITS-1:0] sample_out;
      logic                    was_clipped;
   } out_sample_type;

   class compressor_scoreboard;
      logic [31:0]       band_regs[NUM_REGS];
      logic [31:0]       envelope[BANDS];
      logic [31:0]       pow_tab[17];
      out_sample_type    pending[$];
      int                mismatches;

      function new();
         longint unsigned c;
         for (int i = 0; i < NUM_REGS; i++) band_regs[i] = REG_DEFAULTS[i];
         for (int b = 0; b < BANDS; b++) envelope[b] = '0;
         pow_tab[0] = 32'h4000_0000;
         c = int_sqrt(64'd1 << 59);
         pow_tab[1] = c[31:0];
         for (int i = 2; i <= 16; i++) begin
            c = int_sqrt(c << 30);
            pow_tab[i] = c[31:0];
         end
         mismatches = 0;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void write_reg(int index, logic [31:0] value);
         if (index < NUM_REGS) band_regs[index] = value;
      endfunction

      function logic signed [15:0] env_to_db(logic [31:0] env);
         longint unsigned m;
         longint          frac, l, db;
         int              p;
         if (env == 0) return DB_AT_ZERO;
         p = 31;
         while (env[p] == 1'b0) p--;
         m = longint'(env) << (30 - p);
         frac = 0;
         for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
               frac = frac | 1;
               m = m >> 1;
            end
         end
         l = longint'(p - 30) * 65536 + frac;
         db = (l * 394566) >>> 24;
         if (db < -32768) db = -32768;
         if (db > 32767) db = 32767;
         return db[15:0];
      endfunction

      function longint reduction_gain(logic [31:0] red);
         longint unsigned t, ip, p;
         t = ((longint'(red) * 10885) >> 8) & 64'hFFFF_FFFF;
         ip = t >> 16;
         p = 64'd1 << 30;
         for (int k = 1; k <= 16; k++)
            if (t[16-k]) p = (p * pow_tab[k]) >> 30;
         if (ip >= 31) p = 0;
         else p = p >> ip;
         return longint'(p >> 14);
      endfunction

      function out_sample_type compress(logic signed [SBITS-1:0] x);
         out_sample_type  res;
         longint          s, acc, scale, copy, g, thr, lvl;
         longint unsigned mag;
         logic [31:0]     r0, r1, env, red;
         logic [15:0]     slope;
         logic [7:0]      att, rel;
         s = x;
         acc = s;
         for (int b = 0; b < BANDS; b++) begin
            r0 = band_regs[2*b];
            r1 = band_regs[2*b+1];
            scale = r0[31:16];
            thr = $signed(r0[15:0]);
            slope = r1[31:16];
            att = r1[15:8];
            rel = r1[7:0];
            copy = s * scale;
            mag = (copy < 0) ? -copy : copy;
            mag = mag >> (SBITS - 16);
            env = envelope[b];
            if (mag > env) env = env + (((mag - env) * att) >> 12);
            else env = env - (((longint'(env) - mag) * rel) >> 12);
            envelope[b] = env;
            lvl = env_to_db(env);
            red = 0;
            if (lvl > thr) red = ((lvl - thr) * slope) >> 16;
            g = reduction_gain(red) - 65536;
            acc = acc + ((copy * g) >>> 32);
         end
         res.was_clipped = 1'b0;
         if (acc > 4194304) begin
            acc = 4194304;
            res.was_clipped = 1'b1;
         end
         if (acc < -4194304) begin
            acc = -4194304;
            res.was_clipped = 1'b1;
         end
         res.sample_out = acc[SBITS-1:0];
         return res;
      endfunction

      function void note_sample(logic signed [SBITS-1:0] x);
         pending.push_back(compress(x));
      endfunction

      function void check_result(logic signed [SBITS-1:0] y, logic clip);
         out_sample_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected output sample %0d clip %0b", y, clip);
            return;
         end
         want = pending.pop_front();
         if (y !== want.sample_out || clip !== want.was_clipped) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: sample_out exp %0d got %0d, was_clipped exp %0b got %0b",
                        want.sample_out, y, want.was_clipped, clip);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [SBITS-1:0] req_sample_in = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [SBITS-1:0] rsp_sample_out;
   logic                    rsp_was_clipped;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   compressor_scoreboard scb = new();
   int  idle_cycles = 0;
   int  burst_left = 0;
   bit  holdoff_go = 0;

   multiband_envelope_compressor #(.BAND_COUNT(BANDS), .SAMPLE_BITS(SBITS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample_out(rsp_sample_out),
      .rsp_was_clipped(rsp_was_clipped),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (rsp_valid && !rsp_stall) scb.check_result(rsp_sample_out, rsp_was_clipped);
         if (idle_cycles >= WATCHDOG) begin
            $display("multiband_envelope_compressor test failed");
            $finish;
         end
      end
   end

   always begin
      int mode;
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(50, 300)) begin
         @(posedge clock);
         if (holdoff_go) begin
            rsp_stall <= 1'b1;
            repeat (HOLDOFF) @(posedge clock);
            holdoff_go = 0;
         end
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic write_csr(int index, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= CSR_INDEX_BITS'(index);
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      scb.write_reg(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(logic signed [SBITS-1:0] x);
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall);
      scb.note_sample(x);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 40)) @(posedge clock);
         else @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic signed [SBITS-1:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 24'($urandom);
         1: return 24'($urandom_range(3800000, 8388607));
         2: return -$signed({1'b0, 23'($urandom_range(3800000, 8388607))});
         3: return $signed(24'($urandom_range(0, 600))) - 24'sd300;
         4: return ($urandom_range(0, 1)) ? FULL_POS : FULL_NEG;
         default: return $signed(24'($urandom_range(0, 8000000))) - 24'sd4000000;
      endcase
   endfunction

   task automatic set_all(logic [31:0] st, logic [31:0] sl, bit randomize);
      for (int b = 0; b < BANDS; b++) begin
         write_csr(2*b,   randomize ? 32'($urandom) : st);
         write_csr(2*b+1, randomize ? 32'($urandom) : sl);
      end
      write_csr(NUM_REGS + $urandom_range(0, 100), $urandom);
      write_csr(255, $urandom);
   endtask

   initial begin
      logic signed [SBITS-1:0] directed[$];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{24'sd0, FULL_POS, FULL_NEG, 24'sd1, -24'sd1, UNITY, -UNITY,
                   UNITY + 24'sd1, -UNITY - 24'sd1, 24'sd300, 24'sd20};
      foreach (directed[i]) send_sample(directed[i]);
      repeat (6) send_sample(FULL_POS);
      repeat (6) send_sample(24'sd0);
      drain();

      // deep reduction: lowest threshold, steepest slope, fastest attack
      set_all(32'hFFFF_8000, 32'hFFFF_FFFF, 0);
      repeat (8) send_sample(FULL_NEG);
      repeat (8) send_sample(24'sd40);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ;
            1: set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
            2: set_all(32'h0000_0000, 32'h0000_0000, 0);
            3: set_all(32'h0001_7FFF, 32'h0001_0101, 0);
            default: set_all('0, '0, 1);
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == 40) holdoff_go = 1;
            send_sample(random_sample());
         end
         drain();
      end

      if (scb.mismatches == 0 && scb.pending.size() == 0) begin
         $display("multiband_envelope_compressor test passed");
      end else begin
         $display("multiband_envelope_compressor test failed");
      end
      $finish;
   end

endmodule
